// ----- rtl/core/ttf_pkg.sv -----
// Shared types, constants and string tables for the typographic text filter.
// No dependencies; used by every module under rtl/core.
package ttf_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int STR_BYTES = 30;
   localparam int STR_BITS = 8 * STR_BYTES;
   localparam int POS_WIDTH = 5;

   localparam logic [2:0] KIND_TEXT = 3'd0;
   localparam logic [2:0] KIND_NOHTML = 3'd1;
   localparam logic [2:0] KIND_RAW = 3'd2;
   localparam logic [2:0] KIND_INLINE = 3'd3;
   localparam logic [2:0] KIND_END = 3'd4;
   localparam logic [2:0] KIND_BLOCK = 3'd5;

   localparam logic CSR_QUOTE_SPAN = 1'b0;
   localparam logic CSR_AMP_SPAN = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic [2:0] token_kind;
      logic       last_in_token;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] out_kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic quote_span_en;
      logic amp_span_en;
   } cfg_type;

   typedef enum logic [3:0] {
      SEG_BYTE,
      SEG_DOTS,
      SEG_DASH,
      SEG_AMPER,
      SEG_ELLIPSIS,
      SEG_MDASH,
      SEG_LSQUO,
      SEG_RSQUO,
      SEG_LDQUO,
      SEG_RDQUO,
      SEG_AMP_SPAN,
      SEG_QUO_SPAN,
      SEG_DQUO_SPAN
   } seg_id_type;

   // One run of output bytes: a table string (or the item's own byte) and its length.
   typedef struct packed {
      logic                 used;
      seg_id_type           id;
      logic [POS_WIDTH-1:0] len_m1;
      logic [2:0]           kind;
   } seg_type;

   // Everything one accepted item emits, in order.
   typedef struct packed {
      seg_type [2:0] seg;
      logic [1:0]    count_m1;
      logic [7:0]    data;
   } cmd_type;

   // Strings are left-aligned, first byte in the top bits.
   function automatic logic [STR_BITS-1:0] seg_string(seg_id_type id);
      logic [STR_BITS-1:0] s;
      unique case (id)
         SEG_DOTS:      s = {"..", 224'd0};
         SEG_DASH:      s = {"-", 232'd0};
         SEG_AMPER:     s = {"&amp", 208'd0};
         SEG_ELLIPSIS:  s = {8'hE2, 8'h80, 8'hA6, 216'd0};
         SEG_MDASH:     s = {8'hE2, 8'h80, 8'h94, 216'd0};
         SEG_LSQUO:     s = {8'hE2, 8'h80, 8'h98, 216'd0};
         SEG_RSQUO:     s = {8'hE2, 8'h80, 8'h99, 216'd0};
         SEG_LDQUO:     s = {8'hE2, 8'h80, 8'h9C, 216'd0};
         SEG_RDQUO:     s = {8'hE2, 8'h80, 8'h9D, 216'd0};
         SEG_AMP_SPAN:  s = {"<span class=\"amp\">&amp;</span>"};
         SEG_QUO_SPAN:  s = {"<span class=\"quo\">", 8'hE2, 8'h80, 8'h98, "</span>", 16'd0};
         SEG_DQUO_SPAN: s = {"<span class=\"dquo\">", 8'hE2, 8'h80, 8'h9C, "</span>", 8'd0};
         default:       s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_char(seg_id_type id, logic [POS_WIDTH-1:0] pos);
      logic [STR_BITS-1:0] sh;
      sh = seg_string(id) << {pos, 3'b000};
      return sh[STR_BITS-1 -: 8];
   endfunction

endpackage

// ----- rtl/core/ttf_front.sv -----
// Front end: accepts tagged bytes, runs the match state machine and emits at most
// one segment list per item. Depends on ttf_pkg.
module ttf_front (
   input  logic             clock,
   input  logic             reset,
   input  ttf_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttf_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output ttf_pkg::cmd_type push_cmd
);

   typedef enum logic [3:0] {
      ST_START,
      ST_DOT,
      ST_DOTDOT,
      ST_DASH,
      ST_DASHDASH,
      ST_AMP,
      ST_AMPA,
      ST_AMPAM,
      ST_AMPAMP
   } state_type;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_M = 8'h6D;
   localparam logic [7:0] CH_P = 8'h70;

   state_type  match_state_ff, match_state_in, mid_state, scan_state;
   logic [7:0] prev_char_ff, prev_char_in;
   logic       run_start_ff, run_start_in;

   ttf_pkg::seg_type       seg_a, seg_b, seg_c;
   ttf_pkg::seg_type [2:0] segs;
   ttf_pkg::cmd_type       cmd;
   logic [1:0]             seg_count;
   logic [7:0]             c;
   logic [2:0]             tk, okind;
   logic                   accept, nohtml, passthru, restart, open_q, wrap_q;

   function automatic ttf_pkg::seg_type mk_seg(ttf_pkg::seg_id_type id,
                                               logic [ttf_pkg::POS_WIDTH-1:0] len_m1,
                                               logic [2:0] kind);
      ttf_pkg::seg_type s;
      s.used = 1'b1;
      s.id = id;
      s.len_m1 = len_m1;
      s.kind = kind;
      return s;
   endfunction

   // Bytes held by a partial match, as they stood; a held double dash flushes as an em dash.
   function automatic ttf_pkg::seg_type pend_seg(state_type st, logic [2:0] kind);
      ttf_pkg::seg_type s;
      unique case (st)
         ST_DOT:      s = mk_seg(ttf_pkg::SEG_DOTS, 5'd0, kind);
         ST_DOTDOT:   s = mk_seg(ttf_pkg::SEG_DOTS, 5'd1, kind);
         ST_DASH:     s = mk_seg(ttf_pkg::SEG_DASH, 5'd0, kind);
         ST_DASHDASH: s = mk_seg(ttf_pkg::SEG_MDASH, 5'd2, ttf_pkg::KIND_TEXT);
         ST_AMP:      s = mk_seg(ttf_pkg::SEG_AMPER, 5'd0, kind);
         ST_AMPA:     s = mk_seg(ttf_pkg::SEG_AMPER, 5'd1, kind);
         ST_AMPAM:    s = mk_seg(ttf_pkg::SEG_AMPER, 5'd2, kind);
         ST_AMPAMP:   s = mk_seg(ttf_pkg::SEG_AMPER, 5'd3, kind);
         default:     s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] want_char(state_type st);
      logic [7:0] w;
      unique case (st)
         ST_DOT:   w = CH_DOT;
         ST_DASH:  w = CH_DASH;
         ST_AMP:   w = CH_A;
         ST_AMPA:  w = CH_M;
         default:  w = CH_P;
      endcase
      return w;
   endfunction

   assign c = req_data.in_byte;
   assign tk = req_data.token_kind;
   assign req_ready = !q_full;
   assign accept = req_valid && !q_full;

   assign passthru = (tk == ttf_pkg::KIND_RAW) || (tk == ttf_pkg::KIND_INLINE) ||
                     (tk == ttf_pkg::KIND_END) || (tk == ttf_pkg::KIND_BLOCK);
   assign nohtml = (tk == ttf_pkg::KIND_NOHTML);
   assign okind = nohtml ? ttf_pkg::KIND_NOHTML : ttf_pkg::KIND_TEXT;
   assign open_q = (prev_char_ff == 8'd0) || (prev_char_ff == CH_LPAREN) ||
                   (prev_char_ff == CH_SPACE) ||
                   ((prev_char_ff >= CH_TAB) && (prev_char_ff <= CH_CR));
   assign wrap_q = run_start_ff && cfg.quote_span_en && !nohtml;

   always_comb begin
      seg_a = '0;
      seg_b = '0;
      seg_c = '0;
      restart = 1'b0;
      mid_state = match_state_ff;

      // Resolve the pending match first; a break flushes it and rescans the byte.
      unique case (match_state_ff)
         ST_DOT, ST_DASH, ST_AMP, ST_AMPA, ST_AMPAM: begin
            if (c == want_char(match_state_ff)) begin
               mid_state = state_type'(match_state_ff + 4'd1);
            end else begin
               seg_a = pend_seg(match_state_ff, okind);
               restart = 1'b1;
            end
         end
         ST_DOTDOT: begin
            if (c == CH_DOT) begin
               seg_a = mk_seg(ttf_pkg::SEG_ELLIPSIS, 5'd2, ttf_pkg::KIND_TEXT);
               mid_state = ST_START;
            end else begin
               seg_a = pend_seg(match_state_ff, okind);
               restart = 1'b1;
            end
         end
         ST_DASHDASH: begin
            seg_a = mk_seg(ttf_pkg::SEG_MDASH, 5'd2, ttf_pkg::KIND_TEXT);
            mid_state = ST_START;
            restart = (c != CH_DASH);
         end
         ST_AMPAMP: begin
            if (c == CH_SEMI && cfg.amp_span_en && !nohtml) begin
               seg_a = mk_seg(ttf_pkg::SEG_AMP_SPAN, 5'd29, ttf_pkg::KIND_INLINE);
               mid_state = ST_START;
            end else begin
               seg_a = pend_seg(match_state_ff, okind);
               restart = 1'b1;
            end
         end
         default: restart = 1'b1;
      endcase

      scan_state = mid_state;
      run_start_in = run_start_ff;
      if (restart) begin
         run_start_in = 1'b0;
         scan_state = ST_START;
         case (c)
            CH_DOT:  scan_state = ST_DOT;
            CH_DASH: scan_state = ST_DASH;
            CH_AMP:  scan_state = ST_AMP;
            CH_SQUOTE: begin
               if (open_q && wrap_q) begin
                  seg_b = mk_seg(ttf_pkg::SEG_QUO_SPAN, 5'd27, ttf_pkg::KIND_INLINE);
               end else begin
                  seg_b = mk_seg(open_q ? ttf_pkg::SEG_LSQUO : ttf_pkg::SEG_RSQUO,
                                 5'd2, ttf_pkg::KIND_TEXT);
               end
            end
            CH_DQUOTE: begin
               if (open_q && wrap_q) begin
                  seg_b = mk_seg(ttf_pkg::SEG_DQUO_SPAN, 5'd28, ttf_pkg::KIND_INLINE);
               end else begin
                  seg_b = mk_seg(open_q ? ttf_pkg::SEG_LDQUO : ttf_pkg::SEG_RDQUO,
                                 5'd2, ttf_pkg::KIND_TEXT);
               end
            end
            default: seg_b = mk_seg(ttf_pkg::SEG_BYTE, 5'd0, okind);
         endcase
      end

      // End of token: flush whatever is still held.
      match_state_in = scan_state;
      if (req_data.last_in_token) begin
         seg_c = pend_seg(scan_state, okind);
         match_state_in = ST_START;
      end
      prev_char_in = c;

      if (passthru) begin
         seg_a = mk_seg(ttf_pkg::SEG_BYTE, 5'd0, tk);
         seg_b = '0;
         seg_c = '0;
         match_state_in = match_state_ff;
         prev_char_in = prev_char_ff;
         run_start_in = run_start_ff;
         if (tk == ttf_pkg::KIND_BLOCK) begin
            match_state_in = ST_START;
            prev_char_in = 8'd0;
            run_start_in = 1'b1;
         end
      end
   end

   assign segs = {seg_c, seg_b, seg_a};

   // Pack the used segments to the front of the list.
   always_comb begin
      cmd = '0;
      seg_count = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (segs[i].used) begin
            cmd.seg[seg_count] = segs[i];
            seg_count = seg_count + 2'd1;
         end
      end
      cmd.count_m1 = seg_count - 2'd1;
      cmd.data = c;
   end

   assign push = accept && (seg_count != 2'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_state_ff <= ST_START;
         prev_char_ff <= 8'd0;
         run_start_ff <= 1'b1;
      end else if (accept) begin
         match_state_ff <= match_state_in;
         prev_char_ff <= prev_char_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

// ----- rtl/core/ttf_queue.sv -----
// Short command queue between the front end and the byte emitter.
// Depends on ttf_pkg for the command type.
module ttf_queue #(
   parameter int DEPTH = ttf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ttf_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ttf_pkg::cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ttf_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/ttf_back.sv -----
// Back end: walks the segments of the head command and emits one byte per
// transfer through an output register. Depends on ttf_pkg.
module ttf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ttf_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttf_pkg::rsp_type rsp_data
);

   logic [1:0]                   seg_idx_ff;
   logic [ttf_pkg::POS_WIDTH-1:0] pos_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   ttf_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   ttf_pkg::seg_type             cur;
   logic                         load, seg_end, cmd_end;

   assign cur = head.seg[seg_idx_ff];
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign seg_end = (pos_ff == cur.len_m1);
   assign cmd_end = seg_end && (seg_idx_ff == head.count_m1);
   assign pop = load && cmd_end;

   always_comb begin
      rsp_data_in.out_byte = (cur.id == ttf_pkg::SEG_BYTE) ? head.data :
                             ttf_pkg::seg_char(cur.id, pos_ff);
      rsp_data_in.out_kind = cur.kind;
      rsp_data_in.last = cmd_end;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_idx_ff <= 2'd0;
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            if (seg_end) begin
               pos_ff <= '0;
               seg_idx_ff <= cmd_end ? 2'd0 : seg_idx_ff + 2'd1;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // Hold the result until the transfer completes.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- rtl/core/typographic_text_filter.sv -----
// Throughput: one input byte per cycle while the command queue has room; one output byte
// per cycle while the receiver is ready, so an item with N result bytes holds the emitter
// for N transfers. Path: with the emitter idle, an accepted item is written to the queue
// and then loaded into the output register, where its first result becomes valid.
// Reset: matcher to start, previous byte 0, run-start flag set, both options off,
// queue and output register empty.
module typographic_text_filter #(
   parameter int QUEUE_DEPTH = ttf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic             csr_wdata
);

   ttf_pkg::cfg_type cfg_ff, cfg_in;
   ttf_pkg::cmd_type q_push_cmd, q_head;
   logic             q_push, q_full, q_pop, q_head_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ttf_pkg::CSR_QUOTE_SPAN: cfg_in.quote_span_en = csr_wdata;
            ttf_pkg::CSR_AMP_SPAN:   cfg_in.amp_span_en = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (q_push),
      .push_cmd  (q_push_cmd)
   );

   ttf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   ttf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("emitter retired a command from an empty queue");

   a_pop_ends_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid && rsp_data.last)
      else $error("retired command did not leave a final result in the output register");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_head_valid |=> q_head_valid)
      else $error("command pushed into an empty queue did not reach the head");
`endif

endmodule
